// ----- hw/rtl/unique_value_deque_core_defines.svh -----
// Assertion macros for the unique value deque core.
// Standalone header; included by the files that carry assertions.
`ifndef UNIQUE_VALUE_DEQUE_CORE_DEFINES_SVH
`define UNIQUE_VALUE_DEQUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, masked while reset is asserted.
`define UVD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, masked while reset is asserted.
`define UVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define UVD_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define UVD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- hw/rtl/uvd_pkg.sv -----
// Package of the unique value deque: sizes, codes, word types, index helpers.
// No dependencies.
package uvd_pkg;

    localparam int DEPTH       = 16;
    localparam int VALUE_WIDTH = 32;

    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SUM_W    = CNT_W + 1;
    localparam int REQ_W    = 2;
    localparam int STAT_W   = 2;
    localparam int IO_VAL_W = 32;
    localparam int IO_CNT_W = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_ADD        = 2'd0,
        REQ_TAKE_FRONT = 2'd1,
        REQ_TAKE_BACK  = 2'd2
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef struct packed {
        t_status                      status;
        logic signed [IO_VAL_W-1:0]   removed_value;
        logic [IO_CNT_W-1:0]          entry_count;
    } t_res;

    typedef struct packed {
        logic                   we;
        logic [IDX_W-1:0]       waddr;
        logic [VALUE_WIDTH-1:0] wdata;
        logic [IDX_W-1:0]       raddr;
    } t_mem_req;

    // Circular slot of the entry at offset off from the head.
    function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(DEPTH)) begin
            sum = sum - SUM_W'(DEPTH);
        end
        return IDX_W'(sum);
    endfunction

    // Sign-extend or trim a stored value to the result word width.
    function automatic logic signed [IO_VAL_W-1:0] widen(
        input logic signed [VALUE_WIDTH-1:0] v);
        return IO_VAL_W'(v);
    endfunction

endpackage

// ----- hw/rtl/uvd_ifs.sv -----
// Valid/ready channel interfaces for requests and responses.
// Depends on uvd_pkg for payload widths.
interface uvd_req_if;
    logic                                      valid;
    logic                                      ready;
    logic [uvd_pkg::REQ_W-1:0]                 req_type;
    logic signed [uvd_pkg::IO_VAL_W-1:0]       value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface uvd_rsp_if;
    logic                                      valid;
    logic                                      ready;
    logic [uvd_pkg::STAT_W-1:0]                status;
    logic signed [uvd_pkg::IO_VAL_W-1:0]       removed_value;
    logic [uvd_pkg::IO_CNT_W-1:0]              entry_count;

    modport source (output valid, output status, output removed_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input entry_count, output ready);
endinterface

// ----- hw/rtl/uvd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module uvd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hw/rtl/uvd_seq.sv -----
// Request sequencer: head/count state, one-entry-per-cycle duplicate scan
// through the single comparator, slot updates. Depends on uvd_pkg.
module uvd_seq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_vld,
    input  logic [uvd_pkg::REQ_W-1:0]           i_req_type,
    input  logic signed [uvd_pkg::IO_VAL_W-1:0] i_value,
    output logic                                o_req_rdy,
    input  logic                                i_out_free,
    input  logic [uvd_pkg::VALUE_WIDTH-1:0]     i_rd_data,
    output uvd_pkg::t_mem_req                   o_mem,
    output logic                                o_res_vld,
    output uvd_pkg::t_res                       o_res
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_RWAIT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state                          r_state, n_state;
    uvd_pkg::t_req                   r_req, n_req;
    logic [uvd_pkg::VALUE_WIDTH-1:0] r_value, n_value;
    logic [uvd_pkg::IDX_W-1:0]       r_head, n_head;
    logic [uvd_pkg::CNT_W-1:0]       r_count, n_count;
    logic [uvd_pkg::IDX_W-1:0]       r_addr, n_addr;
    logic [uvd_pkg::CNT_W-1:0]       r_issued, n_issued;
    logic                            r_va, n_va;
    logic                            r_vb, n_vb;
    logic                            r_hit, n_hit;
    logic                            w_match;

    // single comparator: RAM word against the pending value
    assign w_match   = (i_rd_data == r_value);
    assign o_req_rdy = (r_state == S_IDLE);

    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_value  = r_value;
        n_head   = r_head;
        n_count  = r_count;
        n_addr   = r_addr;
        n_issued = r_issued;
        n_va     = r_va;
        n_vb     = r_vb;
        n_hit    = r_hit;

        o_mem.we    = 1'b0;
        o_mem.waddr = uvd_pkg::slot_at(r_head, r_count);
        o_mem.wdata = r_value;
        o_mem.raddr = r_addr;

        o_res_vld           = 1'b0;
        o_res.status        = uvd_pkg::ST_OK;
        o_res.removed_value = '0;
        o_res.entry_count   = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req_vld) begin
                    n_req   = uvd_pkg::t_req'(i_req_type);
                    n_value = uvd_pkg::VALUE_WIDTH'($unsigned(i_value));
                    n_hit   = 1'b0;
                    n_va    = 1'b0;
                    n_vb    = 1'b0;
                    if (n_req == uvd_pkg::REQ_ADD && r_count != '0) begin
                        n_addr   = r_head;
                        n_issued = uvd_pkg::CNT_W'(1);
                        n_va     = 1'b1;
                        n_state  = S_SCAN;
                    end else if ((n_req == uvd_pkg::REQ_TAKE_FRONT ||
                                  n_req == uvd_pkg::REQ_TAKE_BACK) && r_count != '0) begin
                        n_addr  = (n_req == uvd_pkg::REQ_TAKE_FRONT) ? r_head :
                                  uvd_pkg::slot_at(r_head, r_count - uvd_pkg::CNT_W'(1));
                        n_state = S_RWAIT;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                // compare the RAM word that r_vb marks valid, issue the next read
                if (r_vb && w_match) begin
                    n_hit = 1'b1;
                end
                n_vb = r_va;
                if (r_issued != r_count) begin
                    n_addr   = uvd_pkg::slot_at(r_head, r_issued);
                    n_issued = r_issued + uvd_pkg::CNT_W'(1);
                    n_va     = 1'b1;
                end else begin
                    n_va = 1'b0;
                end
                if (r_issued == r_count && !r_va && !r_vb) begin
                    n_state = S_DONE;
                end
            end
            S_RWAIT: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_res_vld = 1'b1;
                    n_state   = S_IDLE;
                    unique case (r_req)
                        uvd_pkg::REQ_ADD: begin
                            if (r_hit) begin
                                o_res.status = uvd_pkg::ST_DUP;
                            end else if (r_count >= uvd_pkg::CNT_W'(uvd_pkg::DEPTH)) begin
                                o_res.status = uvd_pkg::ST_FULL;
                            end else begin
                                o_mem.we = 1'b1;
                                n_count  = r_count + uvd_pkg::CNT_W'(1);
                            end
                        end
                        uvd_pkg::REQ_TAKE_FRONT: begin
                            if (r_count == '0) begin
                                o_res.status = uvd_pkg::ST_EMPTY;
                            end else begin
                                o_res.removed_value = uvd_pkg::widen(i_rd_data);
                                n_head  = uvd_pkg::slot_at(r_head, uvd_pkg::CNT_W'(1));
                                n_count = r_count - uvd_pkg::CNT_W'(1);
                            end
                        end
                        uvd_pkg::REQ_TAKE_BACK: begin
                            if (r_count == '0) begin
                                o_res.status = uvd_pkg::ST_EMPTY;
                            end else begin
                                o_res.removed_value = uvd_pkg::widen(i_rd_data);
                                n_count = r_count - uvd_pkg::CNT_W'(1);
                            end
                        end
                        default: begin
                            // unused request code: report ok, change nothing
                        end
                    endcase
                    o_res.entry_count = uvd_pkg::IO_CNT_W'(n_count);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_count <= '0;
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_va    <= n_va;
            r_vb    <= n_vb;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_value  <= n_value;
        r_addr   <= n_addr;
        r_issued <= n_issued;
    end

endmodule

// ----- hw/rtl/unique_value_deque_core.sv -----
// Top level of the unique value deque: slot RAM, sequencer, response register.
// Depends on uvd_pkg, uvd_ifs, uvd_ram, uvd_seq and the assertion macro header.
//
//  channel   direction  modport  payload
//  i_req     in         sink     req_type, value
//  o_rsp     out        source   status, removed_value, entry_count
//
// Timing: a removal passes through the read-wait and done states (straight to
// done on an empty store, as for the unused request code); an add scans its N
// stored entries, then goes to done (straight to done on an empty store), paced by
// the single RAM read port that feeds the comparator one entry per cycle.
// Reset: synchronous, active low; clears head and count, slot contents stay
// undefined until written. A stalled response holds in the output register;
// the next request is taken meanwhile and finishes once that register frees.
`include "unique_value_deque_core_defines.svh"

module unique_value_deque_core (
    input logic        i_clk,
    input logic        i_rst_n,
    uvd_req_if.sink    i_req,
    uvd_rsp_if.source  o_rsp
);

    uvd_pkg::t_mem_req               w_mem;
    logic [uvd_pkg::VALUE_WIDTH-1:0] w_rd_data;
    logic                            w_res_vld;
    uvd_pkg::t_res                   w_res;
    logic                            w_out_free;

    logic                            r_out_vld;
    uvd_pkg::t_res                   r_out;

    // output register can take a word when empty or being drained this cycle
    assign w_out_free = !r_out_vld || o_rsp.ready;

    uvd_ram #(
        .WIDTH (uvd_pkg::VALUE_WIDTH),
        .DEPTH (uvd_pkg::DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rd_data)
    );

    uvd_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_vld  (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_value    (i_req.value),
        .o_req_rdy  (i_req.ready),
        .i_out_free (w_out_free),
        .i_rd_data  (w_rd_data),
        .o_mem      (w_mem),
        .o_res_vld  (w_res_vld),
        .o_res      (w_res)
    );

    // Hold the response word until taken; load a new one when offered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res_vld) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_vld) begin
            r_out <= w_res;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.status        = r_out.status;
    assign o_rsp.removed_value = r_out.removed_value;
    assign o_rsp.entry_count   = r_out.entry_count;

    // a taken request drops ready for at least the next cycle
    `UVD_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    // the sequencer never overwrites a response word that is still waiting
    `UVD_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_res_vld, w_out_free)
    // the reported count stays within the store
    `UVD_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, o_rsp.valid, o_rsp.entry_count <= uvd_pkg::IO_CNT_W'(uvd_pkg::DEPTH))
    // a response with a status other than ok returns a zero removed value
    `UVD_ASSERT_NOW(a_removed_zero, i_clk, i_rst_n, o_rsp.valid && o_rsp.status != uvd_pkg::ST_OK, o_rsp.removed_value == '0)

endmodule
